@@ rtl/cache_packet_parser_top_assert.svh @@
// assertion macros for the cache packet parser
`ifndef CACHE_PACKET_PARSER_TOP_ASSERT_SVH
`define CACHE_PACKET_PARSER_TOP_ASSERT_SVH

// condition that must hold whenever the antecedent is true, same cycle
`define CPP_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition that must hold in the cycle after the antecedent
`define CPP_IMPLIES_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cpp_pkg.sv @@
// shared types, constants and helpers of the cache packet parser
package cpp_pkg;

    localparam int HdrLen     = 20;
    localparam int HdrOffW    = 5;
    localparam int QueueDepth = 2;

    localparam logic [HdrOffW-1:0] HdrLastOff = HdrOffW'(HdrLen - 1);

    typedef enum logic [2:0] {
        PhHeader = 3'd0,
        PhMsg    = 3'd1,
        PhKey    = 3'd2,
        PhValue  = 3'd3,
        PhDone   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KindHeader  = 2'd0,
        KindPayload = 2'd1,
        KindError   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SegMessage = 2'd0,
        SegKey     = 2'd1,
        SegValue   = 2'd2
    } seg_t;

    typedef struct packed {
        kind_t        kind;
        logic [15:0]  packet_id;
        logic [7:0]   operation;
        logic [7:0]   status_code;
        logic [7:0]   flag_bits;
        logic [15:0]  message_length;
        logic [31:0]  timestamp;
        logic [31:0]  key_length;
        logic [31:0]  value_length;
        logic [7:0]   payload_byte;
        seg_t         segment;
        logic         packet_last;
    } res_t;

    // one queue slot: a result, optionally followed by a truncation error
    typedef struct packed {
        res_t res;
        logic err_follow;
    } entry_t;

    function automatic res_t err_result();
        res_t r;
        r      = '0;
        r.kind = KindError;
        return r;
    endfunction

endpackage

@@ rtl/cpp_parser.sv @@
// byte parser: header shift registers, segment tracking and result build
module cpp_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  logic [7:0]      data_byte,
    input  logic            buffer_end,
    output logic            push_valid,
    output cpp_pkg::entry_t push_entry
);
    import cpp_pkg::*;

    logic [HdrOffW-1:0] offset_reg, offset_next;
    phase_t             phase_reg, phase_next, phase_after;
    logic [31:0]        remaining_reg, remaining_next, remaining_after, remaining_dec;
    logic [15:0]        id_reg, id_next;
    logic [23:0]        osf_reg, osf_next;
    logic [15:0]        msg_len_reg, msg_len_next;
    logic [31:0]        time_reg, time_next;
    logic [31:0]        key_len_reg, key_len_next;
    logic [31:0]        value_len_reg, value_len_next;
    res_t               res0;
    logic               res0_valid;
    logic               err;

    always_comb begin
        offset_next     = offset_reg;
        id_next         = id_reg;
        osf_next        = osf_reg;
        msg_len_next    = msg_len_reg;
        time_next       = time_reg;
        key_len_next    = key_len_reg;
        value_len_next  = value_len_reg;
        phase_after     = phase_reg;
        remaining_after = remaining_reg;
        remaining_dec   = remaining_reg - 32'd1;
        res0            = '0;
        res0_valid      = 1'b0;
        case (phase_reg)
            PhHeader: begin
                if (offset_reg inside {[5'd0:5'd1]}) begin
                    id_next = {id_reg[7:0], data_byte};
                end else if (offset_reg inside {[5'd2:5'd4]}) begin
                    osf_next = {osf_reg[15:0], data_byte};
                end else if (offset_reg inside {[5'd5:5'd6]}) begin
                    msg_len_next = {msg_len_reg[7:0], data_byte};
                end else if (offset_reg inside {[5'd8:5'd11]}) begin
                    time_next = {time_reg[23:0], data_byte};
                end else if (offset_reg inside {[5'd12:5'd15]}) begin
                    key_len_next = {key_len_reg[23:0], data_byte};
                end else if (offset_reg != 5'd7) begin
                    value_len_next = {value_len_reg[23:0], data_byte};
                end

                if (offset_reg >= HdrLastOff) begin
                    // first non-empty segment, or done for an empty payload
                    if (msg_len_reg != 16'd0) begin
                        phase_after     = PhMsg;
                        remaining_after = {16'd0, msg_len_reg};
                    end else if (key_len_reg != 32'd0) begin
                        phase_after     = PhKey;
                        remaining_after = key_len_reg;
                    end else if (value_len_next != 32'd0) begin
                        phase_after     = PhValue;
                        remaining_after = value_len_next;
                    end else begin
                        phase_after     = PhDone;
                        remaining_after = 32'd0;
                    end
                    res0_valid          = 1'b1;
                    res0.kind           = KindHeader;
                    res0.packet_id      = id_reg;
                    res0.operation      = osf_reg[23:16];
                    res0.status_code    = osf_reg[15:8];
                    res0.flag_bits      = osf_reg[7:0];
                    res0.message_length = msg_len_reg;
                    res0.timestamp      = time_reg;
                    res0.key_length     = key_len_reg;
                    res0.value_length   = value_len_next;
                end else begin
                    offset_next = offset_reg + 5'd1;
                end
            end
            PhMsg, PhKey, PhValue: begin
                remaining_after = remaining_dec;
                if (remaining_dec == 32'd0) begin
                    if (phase_reg == PhMsg && key_len_reg != 32'd0) begin
                        phase_after     = PhKey;
                        remaining_after = key_len_reg;
                    end else if (phase_reg != PhValue && value_len_reg != 32'd0) begin
                        phase_after     = PhValue;
                        remaining_after = value_len_reg;
                    end else begin
                        phase_after = PhDone;
                    end
                end
                res0_valid        = 1'b1;
                res0.kind         = KindPayload;
                res0.payload_byte = data_byte;
                case (phase_reg)
                    PhMsg:   res0.segment = SegMessage;
                    PhKey:   res0.segment = SegKey;
                    default: res0.segment = SegValue;
                endcase
            end
            default: begin
                // past the packet: byte dropped
            end
        endcase
        res0.packet_last = (phase_after == PhDone);

        // buffer ended while the packet is still open
        err = buffer_end && (phase_after != PhDone);

        if (buffer_end) begin
            offset_next    = '0;
            phase_next     = PhHeader;
            remaining_next = 32'd0;
        end else begin
            phase_next     = phase_after;
            remaining_next = remaining_after;
        end

        push_valid = fire && (res0_valid || err);
        if (res0_valid) begin
            push_entry.res        = res0;
            push_entry.err_follow = err;
        end else begin
            push_entry.res        = err_result();
            push_entry.err_follow = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            phase_reg     <= PhHeader;
            remaining_reg <= 32'd0;
        end else if (fire) begin
            offset_reg    <= offset_next;
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
        end
    end

    // header fields are fully overwritten before use
    always_ff @(posedge aclk) begin
        if (fire) begin
            id_reg        <= id_next;
            osf_reg       <= osf_next;
            msg_len_reg   <= msg_len_next;
            time_reg      <= time_next;
            key_len_reg   <= key_len_next;
            value_len_reg <= value_len_next;
        end
    end

endmodule

@@ rtl/cpp_out_queue.sv @@
// result queue with follow-up error sequencing on the output side
module cpp_out_queue #(
    parameter int DEPTH = cpp_pkg::QueueDepth
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  cpp_pkg::entry_t push_entry,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output cpp_pkg::res_t   out_res
);
    import cpp_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    entry_t            slots_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              err_phase_reg, err_phase_next;
    entry_t            head;
    logic              take;
    logic              pop;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        if (p == PtrW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PtrW'(1);
    endfunction

    assign head      = slots_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign in_ready  = (count_reg != CntW'(DEPTH));
    assign out_res   = err_phase_reg ? err_result() : head.res;
    assign take      = out_valid && out_ready;
    // a slot with a trailing error is released only after the error goes out
    assign pop       = take && (!head.err_follow || err_phase_reg);

    always_comb begin
        wr_ptr_next    = push_valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next    = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next     = count_reg + CntW'(push_valid) - CntW'(pop);
        err_phase_next = take ? (head.err_follow && !err_phase_reg) : err_phase_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            err_phase_reg <= 1'b0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            err_phase_reg <= err_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/cache_packet_parser_top.sv @@
// Cache packet parser, top level.
// Input channel (s_): one byte of a received buffer per request, with
// s_buffer_end high on the buffer's last byte. The first 20 bytes of a
// packet form a big-endian header; the bytes after it are message, key and
// value payload. Result channel (m_): a header request on the 20th byte, one
// payload request per payload byte tagged by segment, packet_last on the
// request that completes the packet, and a truncation error after the last
// result when the buffer ends early. Bytes past the packet give nothing.
// A result is registered in the result queue before it shows on m_.
// Throughput: one byte per cycle while s_ready is high; a byte that also
// truncates the packet sends its error request after its own result.
// A result queue of QUEUE_DEPTH entries sits between the parser and m_, so
// s_ready depends only on queue occupancy; when the receiver stalls the
// queue fills and s_ready drops until a slot frees up.
// Reset empties the queue and arms the parser for header byte 0; every
// buffer end rearms it the same way.
`include "cache_packet_parser_top_assert.svh"

module cache_packet_parser_top #(
    parameter int QUEUE_DEPTH = cpp_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_buffer_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [15:0] m_packet_id,
    output logic [7:0]  m_operation,
    output logic [7:0]  m_status_code,
    output logic [7:0]  m_flag_bits,
    output logic [15:0] m_message_length,
    output logic [31:0] m_timestamp,
    output logic [31:0] m_key_length,
    output logic [31:0] m_value_length,
    output logic [7:0]  m_payload_byte,
    output logic [1:0]  m_segment,
    output logic        m_packet_last
);
    import cpp_pkg::*;

    logic   fire;
    logic   push_valid;
    entry_t push_entry;
    res_t   out_res;

    assign fire = s_valid && s_ready;

    cpp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .data_byte  (s_data_byte),
        .buffer_end (s_buffer_end),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    cpp_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .in_ready   (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_res    (out_res)
    );

    assign m_result_kind    = 2'(out_res.kind);
    assign m_packet_id      = out_res.packet_id;
    assign m_operation      = out_res.operation;
    assign m_status_code    = out_res.status_code;
    assign m_flag_bits      = out_res.flag_bits;
    assign m_message_length = out_res.message_length;
    assign m_timestamp      = out_res.timestamp;
    assign m_key_length     = out_res.key_length;
    assign m_value_length   = out_res.value_length;
    assign m_payload_byte   = out_res.payload_byte;
    assign m_segment        = 2'(out_res.segment);
    assign m_packet_last    = out_res.packet_last;

    `CPP_IMPLIES(a_kind_legal, m_valid, m_result_kind == 2'(KindHeader) || m_result_kind == 2'(KindPayload) || m_result_kind == 2'(KindError), "illegal result kind")
    `CPP_IMPLIES(a_err_clean, m_valid && m_result_kind == 2'(KindError), m_packet_id == 16'd0 && m_key_length == 32'd0 && m_payload_byte == 8'd0 && m_segment == 2'd0 && !m_packet_last, "error request carries data")
    `CPP_IMPLIES(a_hdr_clean, m_valid && m_result_kind == 2'(KindHeader), m_payload_byte == 8'd0 && m_segment == 2'd0, "header request carries payload")
    `CPP_IMPLIES(a_stall_owned, !s_ready, m_valid, "input stalled with empty result queue")

endmodule
